### rtl/core/aarm_pkg.sv
// ----------------------------------------------------------------------------
// aarm_pkg: shared types and constants
// Word layout of the CORDIC cell row and the arctangent table.
// ----------------------------------------------------------------------------
package aarm_pkg;

  localparam int AXIS_W  = 16;
  localparam int XY_W    = 34;   // Q30 cos/sin with headroom for the gain
  localparam int Z_W     = 33;   // residual angle, 2^32 per turn

  typedef struct packed {
    logic                     valid;
    logic                     neg;
    logic signed [XY_W-1:0]   x;
    logic signed [XY_W-1:0]   y;
    logic signed [Z_W-1:0]    z;
    logic signed [AXIS_W-1:0] ax;
    logic signed [AXIS_W-1:0] ay;
    logic signed [AXIS_W-1:0] az;
  } aarm_cell_t;

  // arctan(2^-i) in 2^32-per-turn units
  function automatic logic signed [Z_W-1:0] atan_turn(input int idx);
    logic [31:0] v;
    unique case (idx)
      0:  v = 32'h20000000;  1:  v = 32'h12E4051D;  2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;  4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;  8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2E;  10: v = 32'h000A2F98;  11: v = 32'h000517CC;
      12: v = 32'h00028BE6;  13: v = 32'h000145F3;  14: v = 32'h0000A2F9;
      15: v = 32'h0000517C;  16: v = 32'h000028BE;  17: v = 32'h0000145F;
      18: v = 32'h00000A2F;  19: v = 32'h00000517;  20: v = 32'h0000028B;
      21: v = 32'h00000145;  22: v = 32'h000000A2;  23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return $signed({1'b0, v});
  endfunction

  localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [XY_W-1:0] Q30_ONE         = 34'sd1073741824;

endpackage

### rtl/core/aarm_if.sv
// ----------------------------------------------------------------------------
// aarm_if: valid/ready channels
// Axis-angle input word and rotation matrix output word.
// ----------------------------------------------------------------------------
interface aarm_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] axis_x;
  logic [15:0] axis_y;
  logic [15:0] axis_z;
  logic [15:0] angle_phase;
  modport source (output valid, axis_x, axis_y, axis_z, angle_phase, input ready);
  modport sink   (input valid, axis_x, axis_y, axis_z, angle_phase, output ready);
endinterface

interface aarm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic        saturated;
  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, saturated,
                  input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, saturated,
                  output ready);
endinterface

### rtl/core/aarm_cordic_cell.sv
// ----------------------------------------------------------------------------
// aarm_cordic_cell: one CORDIC rotation
// Rotate by +/- arctan(2^-STEP) and pass the word on to the next cell.
// ----------------------------------------------------------------------------
module aarm_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  aarm_pkg::aarm_cell_t cell_in,
  output aarm_pkg::aarm_cell_t cell_out
);
  import aarm_pkg::*;

  aarm_cell_t cell_next;

  always_comb begin
    cell_next = cell_in;
    if (cell_in.z >= 0) begin
      cell_next.x = cell_in.x - (cell_in.y >>> STEP);
      cell_next.y = cell_in.y + (cell_in.x >>> STEP);
      cell_next.z = cell_in.z - atan_turn(STEP);
    end else begin
      cell_next.x = cell_in.x + (cell_in.y >>> STEP);
      cell_next.y = cell_in.y - (cell_in.x >>> STEP);
      cell_next.z = cell_in.z + atan_turn(STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else if (en) begin
      cell_out <= cell_next;
    end
  end

endmodule

### rtl/core/aarm_product.sv
// ----------------------------------------------------------------------------
// aarm_product: Rodrigues products and sums
// Three stages: axis pair products, scaling by d and sin, sums with rounding and clipping.
// ----------------------------------------------------------------------------
module aarm_product #(
  parameter int FRACTION_BITS = 14
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  aarm_pkg::aarm_cell_t cell_in,
  output logic                 res_valid,
  output logic [15:0]          res_m [9],
  output logic                 res_sat
);
  import aarm_pkg::*;

  localparam int PW = 2 * AXIS_W;          // pair product
  localparam int TW = PW + XY_W;           // term width
  localparam int SW = TW + 2;              // sum width
  localparam int FS = 30 - FRACTION_BITS;
  localparam logic signed [TW-1:0] HALF_D = TW'(1) <<< (2 * FRACTION_BITS - 1);
  localparam logic signed [TW-1:0] HALF_S = TW'(1) <<< (FRACTION_BITS - 1);
  localparam logic signed [SW-1:0] HALF_F = (FS == 0) ? '0 : (SW'(1) <<< ((FS == 0) ? 0 : FS - 1));

  // stage 1: pair products, fix the sign of cos/sin, d = 1 - cos
  logic                     v1;
  logic signed [PW-1:0]     pxx, pyy, pzz, pxy, pxz, pyz;
  logic signed [XY_W-1:0]   c1, s1, d1;
  logic signed [AXIS_W-1:0] ax1, ay1, az1;
  logic signed [XY_W-1:0]   c_fix;

  assign c_fix = cell_in.neg ? -cell_in.x : cell_in.x;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1  <= cell_in.valid;
      pxx <= cell_in.ax * cell_in.ax;
      pyy <= cell_in.ay * cell_in.ay;
      pzz <= cell_in.az * cell_in.az;
      pxy <= cell_in.ax * cell_in.ay;
      pxz <= cell_in.ax * cell_in.az;
      pyz <= cell_in.ay * cell_in.az;
      c1  <= c_fix;
      s1  <= cell_in.neg ? -cell_in.y : cell_in.y;
      d1  <= Q30_ONE - c_fix;
      ax1 <= cell_in.ax;
      ay1 <= cell_in.ay;
      az1 <= cell_in.az;
    end
  end

  // stage 2: scale by d and by sin, round each term to Q30
  logic                 v2;
  logic signed [TW-1:0] txx, tyy, tzz, txy, txz, tyz, tsx, tsy, tsz, c2;

  function automatic logic signed [TW-1:0] rnd_d(input logic signed [PW-1:0] p,
                                                 input logic signed [XY_W-1:0] d);
    logic signed [TW-1:0] full;
    full = TW'(p) * TW'(d);
    return (full + HALF_D) >>> (2 * FRACTION_BITS);
  endfunction

  function automatic logic signed [TW-1:0] rnd_s(input logic signed [AXIS_W-1:0] a,
                                                 input logic signed [XY_W-1:0] s);
    logic signed [TW-1:0] full;
    full = TW'(a) * TW'(s);
    return (full + HALF_S) >>> FRACTION_BITS;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2  <= v1;
      txx <= rnd_d(pxx, d1);
      tyy <= rnd_d(pyy, d1);
      tzz <= rnd_d(pzz, d1);
      txy <= rnd_d(pxy, d1);
      txz <= rnd_d(pxz, d1);
      tyz <= rnd_d(pyz, d1);
      tsx <= rnd_s(ax1, s1);
      tsy <= rnd_s(ay1, s1);
      tsz <= rnd_s(az1, s1);
      c2  <= TW'(c1);
    end
  end

  // stage 3: sums, round to the output format and clip
  logic signed [SW-1:0] sum [9];
  logic signed [SW-1:0] rv;
  logic [8:0]           clip;

  always_comb begin
    sum[0] = SW'(c2) + SW'(txx);
    sum[1] = SW'(txy) - SW'(tsz);
    sum[2] = SW'(txz) + SW'(tsy);
    sum[3] = SW'(txy) + SW'(tsz);
    sum[4] = SW'(c2) + SW'(tyy);
    sum[5] = SW'(tyz) - SW'(tsx);
    sum[6] = SW'(txz) - SW'(tsy);
    sum[7] = SW'(tyz) + SW'(tsx);
    sum[8] = SW'(c2) + SW'(tzz);
    rv = '0;
    for (int k = 0; k < 9; k++) begin
      rv = (sum[k] + HALF_F) >>> FS;
      if (rv > SW'(32767)) begin
        res_m[k] = 16'h7FFF;
        clip[k]  = 1'b1;
      end else if (rv < -SW'(32768)) begin
        res_m[k] = 16'h8000;
        clip[k]  = 1'b1;
      end else begin
        res_m[k] = rv[15:0];
        clip[k]  = 1'b0;
      end
    end
  end

  assign res_valid = v2;
  assign res_sat   = |clip;

endmodule

### rtl/core/axis_angle_rotation_matrix_top.sv
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix_top: axis-angle to 3x3 rotation matrix
// Rodrigues form with a pipelined CORDIC for cos and sin.
// ----------------------------------------------------------------------------
// Takes an axis (Q2.14) and a 16-bit phase (65536 = one turn) and returns the
// nine row-major matrix entries in Q2.14, clipped, with a flag when any entry
// was clipped. One word is accepted every cycle unless the pipeline holds; it
// has CORDIC_STEPS + 4 register stages: a fold register, one cell per CORDIC
// rotation, two product registers (the sums, rounding and clipping sit in
// front of the output register) and the output register. The whole pipeline
// advances together and holds only while a finished word waits at the output
// and the sink is not ready.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix_top #(
  parameter int CORDIC_STEPS  = 16,
  parameter int FRACTION_BITS = 14
) (
  input logic        clk,
  input logic        rst,
  aarm_in_if.sink    axis_in,
  aarm_out_if.source matrix_out
);
  import aarm_pkg::*;

  logic        en;
  aarm_cell_t  fold_next;
  aarm_cell_t  fold;
  aarm_cell_t  chain [CORDIC_STEPS+1];
  logic        res_valid;
  logic [15:0] res_m [9];
  logic        res_sat;
  logic        out_valid;
  logic [15:0] out_m [9];
  logic        out_sat;

  // advance everything unless a result is stuck at the output
  assign en            = !out_valid || matrix_out.ready;
  assign axis_in.ready = en;

  // fold the phase into a quarter turn either side of zero; note the negation
  always_comb begin
    logic signed [Z_W-1:0] z0;
    z0 = Z_W'($signed({axis_in.angle_phase, 16'h0}));
    fold_next.valid = axis_in.valid;
    fold_next.neg   = 1'b0;
    fold_next.x     = CORDIC_GAIN_Q30;
    fold_next.y     = '0;
    fold_next.ax    = $signed(axis_in.axis_x);
    fold_next.ay    = $signed(axis_in.axis_y);
    fold_next.az    = $signed(axis_in.axis_z);
    if (z0 > (Z_W'(1) <<< 30)) begin
      fold_next.z   = z0 - (Z_W'(1) <<< 31);
      fold_next.neg = 1'b1;
    end else if (z0 < -(Z_W'(1) <<< 30)) begin
      fold_next.z   = z0 + (Z_W'(1) <<< 31);
      fold_next.neg = 1'b1;
    end else begin
      fold_next.z   = z0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fold.valid <= 1'b0;
    end else if (en) begin
      fold <= fold_next;
    end
  end

  assign chain[0] = fold;

  // row of CORDIC cells, one rotation each
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    aarm_cordic_cell #(.STEP(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .cell_in  (chain[i]),
      .cell_out (chain[i+1])
    );
  end

  aarm_product #(.FRACTION_BITS(FRACTION_BITS)) u_product (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cell_in   (chain[CORDIC_STEPS]),
    .res_valid (res_valid),
    .res_m     (res_m),
    .res_sat   (res_sat)
  );

  // output register: hold the word until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= res_valid;
      out_m     <= res_m;
      out_sat   <= res_sat;
    end
  end

  assign matrix_out.valid     = out_valid;
  assign matrix_out.m00       = out_m[0];
  assign matrix_out.m01       = out_m[1];
  assign matrix_out.m02       = out_m[2];
  assign matrix_out.m10       = out_m[3];
  assign matrix_out.m11       = out_m[4];
  assign matrix_out.m12       = out_m[5];
  assign matrix_out.m20       = out_m[6];
  assign matrix_out.m21       = out_m[7];
  assign matrix_out.m22       = out_m[8];
  assign matrix_out.saturated = out_sat;

endmodule

### dv/axis_angle_rotation_matrix_top_tb.sv
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix_top_tb: rotation matrix block testbench
// Drives axis-angle words through the valid/ready input, predicts each matrix
// with an independent fixed-point CORDIC and Rodrigues model, and compares
// every output word field by field, in order, under random gaps and stalls.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix_top_tb;
  import aarm_pkg::*;

  localparam int STEPS   = 16;
  localparam int FRAC    = 14;
  localparam int LATENCY = STEPS + 5;

  typedef struct {
    logic [15:0] m [9];
    logic        sat;
  } matrix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  aarm_in_if  axis_in ();
  aarm_out_if matrix_out ();

  axis_angle_rotation_matrix_top #(.CORDIC_STEPS(STEPS), .FRACTION_BITS(FRAC)) dut (
    .clk(clk), .rst(rst), .axis_in(axis_in), .matrix_out(matrix_out)
  );

  matrix_t pending_matrices[$];
  int      errors = 0;
  bit      long_hold = 1'b0;   // set by a test to starve the output for a while
  int      burst_max = 8;
  int      gap_max = 4;

  initial forever #1 clk = ~clk;

  // Arctangent table, 2^32 per turn.
  function automatic longint arctan_step(input int i);
    longint tbl [24] = '{
      'h20000000, 'h12E4051D, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
      'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2E, 'h000A2F98, 'h000517CC,
      'h00028BE6, 'h000145F3, 'h0000A2F9, 'h0000517C, 'h000028BE, 'h0000145F,
      'h00000A2F, 'h00000517, 'h0000028B, 'h00000145, 'h000000A2, 'h00000051};
    return tbl[i];
  endfunction

  // Round half upward, then arithmetic shift (>>> on longint floors).
  function automatic longint round_down_by(input longint v, input int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic [15:0] clip_entry(input longint q30, inout logic sat);
    longint v;
    v = round_down_by(q30, 30 - FRAC);
    if (v > 32767) begin
      v = 32767;
      sat = 1'b1;
    end else if (v < -32768) begin
      v = -32768;
      sat = 1'b1;
    end
    return v[15:0];
  endfunction

  function automatic matrix_t rotation_matrix(input logic [15:0] ax, input logic [15:0] ay,
                                              input logic [15:0] az,
                                              input logic [15:0] phase);
    matrix_t r;
    longint  a [3];
    longint  z, x, y, nx, c, s, d;
    longint  pd [3][3];
    longint  ps [3];
    bit      neg;
    a[0] = longint'($signed(ax));
    a[1] = longint'($signed(ay));
    a[2] = longint'($signed(az));
    z = longint'({phase, 16'h0000});
    x = 652032874;
    y = 0;
    neg = 1'b0;
    // fold into a quarter turn either side of zero
    if (z >= (64'sd1 <<< 31)) z -= (64'sd1 <<< 32);
    if (z > (64'sd1 <<< 30)) begin
      z -= (64'sd1 <<< 31);
      neg = 1'b1;
    end else if (z < -(64'sd1 <<< 30)) begin
      z += (64'sd1 <<< 31);
      neg = 1'b1;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= arctan_step(i);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += arctan_step(i);
      end
      x = nx;
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
    d = (64'sd1 <<< 30) - c;
    for (int i = 0; i < 3; i++) begin
      ps[i] = round_down_by(a[i] * s, FRAC);
      for (int j = 0; j < 3; j++) pd[i][j] = round_down_by(a[i] * a[j] * d, 2 * FRAC);
    end
    r.sat = 1'b0;
    r.m[0] = clip_entry(c + pd[0][0], r.sat);
    r.m[1] = clip_entry(pd[0][1] - ps[2], r.sat);
    r.m[2] = clip_entry(pd[0][2] + ps[1], r.sat);
    r.m[3] = clip_entry(pd[0][1] + ps[2], r.sat);
    r.m[4] = clip_entry(c + pd[1][1], r.sat);
    r.m[5] = clip_entry(pd[1][2] - ps[0], r.sat);
    r.m[6] = clip_entry(pd[0][2] - ps[1], r.sat);
    r.m[7] = clip_entry(pd[1][2] + ps[0], r.sat);
    r.m[8] = clip_entry(c + pd[2][2], r.sat);
    return r;
  endfunction

  // Offer one word, hold it until accepted; gaps come from the burst logic.
  int burst_left = 0;
  task automatic send_word(input logic [15:0] ax, input logic [15:0] ay,
                           input logic [15:0] az, input logic [15:0] phase);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        axis_in.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, burst_max);
    end
    axis_in.valid       <= 1'b1;
    axis_in.axis_x      <= ax;
    axis_in.axis_y      <= ay;
    axis_in.axis_z      <= az;
    axis_in.angle_phase <= phase;
    @(posedge clk);
    while (!axis_in.ready) @(posedge clk);
    pending_matrices.push_back(rotation_matrix(ax, ay, az, phase));
    burst_left--;
  endtask

  task automatic drain_results();
    axis_in.valid <= 1'b0;
    burst_left = 0;
    while (pending_matrices.size() != 0) @(posedge clk);
  endtask

  // Receiver stall pattern: a slowly changing stall probability, plus the long hold.
  int stall_pct = 0;
  initial begin
    matrix_out.ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold) matrix_out.ready <= 1'b0;
      else begin
        if ($urandom_range(0, 63) == 0) stall_pct = $urandom_range(0, 3) * 25;
        matrix_out.ready <= ($urandom_range(1, 100) > stall_pct);
      end
    end
  end

  // Compare every accepted output word with the oldest prediction.
  always @(posedge clk) begin
    matrix_t exp_m;
    logic [15:0] got [9];
    if (!rst && matrix_out.valid && matrix_out.ready) begin
      got = '{matrix_out.m00, matrix_out.m01, matrix_out.m02, matrix_out.m10,
              matrix_out.m11, matrix_out.m12, matrix_out.m20, matrix_out.m21,
              matrix_out.m22};
      if (pending_matrices.size() == 0) begin
        $display("%0t: unexpected output word", $time);
        errors++;
      end else begin
        exp_m = pending_matrices.pop_front();
        for (int k = 0; k < 9; k++)
          if (got[k] !== exp_m.m[k]) begin
            $display("%0t: m%0d%0d expected %h actual %h", $time, k / 3, k % 3,
                     exp_m.m[k], got[k]);
            errors++;
          end
        if (matrix_out.saturated !== exp_m.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, exp_m.sat,
                   matrix_out.saturated);
          errors++;
        end
      end
    end
  end

  // Random 16-bit word, any bit pattern.
  function automatic logic [15:0] rand_word();
    return 16'($urandom());
  endfunction

  task automatic test_directed();
    logic [15:0] phases [8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h2000,
                                16'h4001, 16'hBFFF, 16'hFFFF};
    foreach (phases[i]) send_word(16'h4000, 16'h0000, 16'h0000, phases[i]);
    send_word(16'h0000, 16'h4000, 16'h0000, 16'h1234);
    send_word(16'h0000, 16'h0000, 16'h4000, 16'h5678);
    send_word(16'h0000, 16'h0000, 16'h0000, 16'h3000);   // zero axis
    send_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000);   // far from unit length
    send_word(16'h8000, 16'h8000, 16'h8000, 16'h6000);
    send_word(16'h8000, 16'h7FFF, 16'h0001, 16'hA000);
    send_word(16'hC000, 16'h0000, 16'h0000, 16'h7FFF);
    send_word(16'h2D41, 16'h2D41, 16'h0000, 16'h1555);   // diagonal unit axis
    drain_results();
  endtask

  task automatic test_random(input int n);
    int   sel;
    logic [15:0] p;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 3);
      p = rand_word();
      if (sel == 0) send_word(rand_word(), rand_word(), rand_word(), p);
      else begin
        // components within unit range, mostly no clipping
        send_word(16'($signed($urandom_range(0, 32768)) - 16384),
                  16'($signed($urandom_range(0, 32768)) - 16384),
                  16'($signed($urandom_range(0, 32768)) - 16384), p);
      end
    end
  endtask

  // Starve the output long enough for the pipeline to fill and stall the input.
  task automatic test_backpressure();
    fork
      begin
        long_hold = 1'b1;
        repeat (4 * LATENCY) @(posedge clk);
        long_hold = 1'b0;
      end
      test_random(3 * LATENCY);
    join
    drain_results();
  endtask

  task automatic test_full_rate();
    burst_max = 200;
    gap_max = 0;
    test_random(400);
    burst_max = 8;
    gap_max = 4;
    drain_results();
  endtask

  initial begin
    axis_in.valid       <= 1'b0;
    axis_in.axis_x      <= '0;
    axis_in.axis_y      <= '0;
    axis_in.axis_z      <= '0;
    axis_in.angle_phase <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(600);
    drain_results();
    test_backpressure();
    test_full_rate();
    test_random(500);
    drain_results();
    repeat (2 * LATENCY) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### filelist.f
rtl/core/aarm_pkg.sv
rtl/core/aarm_if.sv
rtl/core/aarm_cordic_cell.sv
rtl/core/aarm_product.sv
rtl/core/axis_angle_rotation_matrix_top.sv
dv/axis_angle_rotation_matrix_top_tb.sv
